@@ rtl/pcmrtp_pkg.sv @@
// Shared constants and types for the PCM RTP packetizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pcmrtp_pkg;

    // Largest chunk in words; a chunk also closes on end of call
    localparam int unsigned CHUNK_WORDS = 480;
    // Chunk word counter width, covers chunk sizes up to 1023 words
    localparam int unsigned CNT_W       = 10;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes of the configuration port
    localparam logic [1:0] REG_STEREO_MODE  = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0] REG_SOURCE_ID    = 2'd2;

    // RTP version 2 in the top bits of the first header word
    localparam logic [31:0] RTP_VERSION_BITS = 32'h8000_0000;

    // Output data bus width: 195 payload bits padded to whole bytes
    localparam int unsigned M_TDATA_W = 200;

    // One classified word travelling from front to back
    typedef struct packed {
        logic signed [15:0] pcm_word;
        logic               nonzero;
        logic               end_of_call;
    } word_item_t;

    // Configuration registers
    typedef struct packed {
        logic        stereo_mode;
        logic [6:0]  payload_type;
        logic [31:0] source_id;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] pcm_word;
        logic [8:0]         word_index;
        logic               chunk_end;
        logic               send_packet;
        logic [31:0]        header_first_word;
        logic [31:0]        rtp_timestamp;
        logic [31:0]        header_source;
        logic [9:0]         payload_bytes;
        logic [31:0]        packets_sent;
        logic [31:0]        bytes_sent;
    } result_t;

endpackage

@@ rtl/pcm_rtp_packetizer_unit.sv @@
// Top level of the PCM RTP packetizer: configuration registers and stream ports.
// Instantiates pcmrtp_front, pcmrtp_queue and pcmrtp_back; depends on pcmrtp_pkg.
//
//  Channel | Direction | Handshake            | Content
//  s_      | in        | s_tvalid / s_tready  | sample (tdata), end_of_call (tlast)
//  m_      | out       | m_tvalid / m_tready  | result word, chunk_end (tlast),
//          |           |                      | send_packet (tuser)
//  cfg_    | in        | cfg_valid/cfg_ready  | register index and write data
//
// One sample per cycle sustained while m_tready stays high; an accepted sample passes
// through the four-entry queue and then the output register before it reaches m_.
// The chunk state update in the back end sets the sustained rate.
// Reset is synchronous on aresetn; all counters and the chunk state clear to zero.
// A stalled m_tready fills the queue, after which s_tready drops.
// Configuration writes are taken in every cycle.
module pcm_rtp_packetizer_unit import pcmrtp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [23:0] sample
    input  logic                 s_tlast,   // end_of_call

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] pcm_word, [24:16] word_index, [56:25] header_first_word,
    // [88:57] rtp_timestamp, [120:89] header_source, [130:121] payload_bytes,
    // [162:131] packets_sent, [194:163] bytes_sent, [199:195] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,   // chunk_end
    output logic                 m_tuser,   // send_packet

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       queue_full;
    logic       queue_not_empty;
    logic       push;
    logic       pop;
    word_item_t push_item;
    word_item_t head_item;
    result_t    result;

    // Decode configuration writes
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEREO_MODE:  cfg_next.stereo_mode  = cfg_data[0];
                REG_PAYLOAD_TYPE: cfg_next.payload_type = cfg_data[6:0];
                REG_SOURCE_ID:    cfg_next.source_id    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pcmrtp_front u_front (
        .in_valid       (s_tvalid),
        .in_sample      ($signed(s_tdata)),
        .in_end_of_call (s_tlast),
        .queue_full     (queue_full),
        .in_ready       (s_tready),
        .push           (push),
        .push_item      (push_item)
    );

    pcmrtp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    pcmrtp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (result)
    );

    // Pack the result onto the output bus
    assign m_tdata = {5'd0,
                      result.bytes_sent,
                      result.packets_sent,
                      result.payload_bytes,
                      result.header_source,
                      result.rtp_timestamp,
                      result.header_first_word,
                      result.word_index,
                      result.pcm_word};
    assign m_tlast = result.chunk_end;
    assign m_tuser = result.send_packet;

endmodule

@@ rtl/pcmrtp_front.sv @@
// Front end: accepts Q2.22 samples, clips and scales them to 16-bit PCM.
// Depends on pcmrtp_pkg.
module pcmrtp_front import pcmrtp_pkg::*; (
    input  logic               in_valid,
    input  logic signed [23:0] in_sample,
    input  logic               in_end_of_call,
    input  logic               queue_full,
    output logic               in_ready,
    output logic               push,
    output word_item_t         push_item
);

    localparam logic signed [23:0] POS_ONE = 24'sh40_0000;
    localparam logic signed [23:0] NEG_ONE = -24'sh40_0000;

    logic signed [38:0] prod;
    logic [38:0]        mag;
    logic [15:0]        shifted;
    logic signed [15:0] word;

    // Scale by 32767 as (x << 15) - x, truncate toward zero
    always_comb begin
        prod    = ($signed({{15{in_sample[23]}}, in_sample}) <<< 15)
                  - $signed({{15{in_sample[23]}}, in_sample});
        mag     = prod[38] ? (~prod + 39'd1) : prod;
        shifted = mag[37:22];
        if (in_sample >= POS_ONE) begin
            word = 16'sh7FFF;
        end else if (in_sample <= NEG_ONE) begin
            word = -16'sh8000;
        end else if (prod[38]) begin
            word = $signed(~shifted + 16'd1);
        end else begin
            word = $signed(shifted);
        end
    end

    // Accept whenever the queue has room
    assign in_ready              = !queue_full;
    assign push                  = in_valid && !queue_full;
    assign push_item.pcm_word    = word;
    assign push_item.nonzero     = (word != 16'sd0);
    assign push_item.end_of_call = in_end_of_call;

endmodule

@@ rtl/pcmrtp_queue.sv @@
// Short FIFO of classified words between front and back.
// Depends on pcmrtp_pkg.
module pcmrtp_queue import pcmrtp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  word_item_t push_item,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output word_item_t head_item
);

    word_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/pcmrtp_back.sv @@
// Back end: chunking, silence decision, RTP header fields and running counts.
// Holds the output register. Depends on pcmrtp_pkg.
module pcmrtp_back import pcmrtp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  word_item_t item,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output result_t    out_data
);

    logic [CNT_W-1:0] words_reg, words_next;
    logic             chunk_nz_reg, chunk_nz_next;
    logic             was_silent_reg, was_silent_next;
    logic [15:0]      seq_reg, seq_next;
    logic [31:0]      ts_reg, ts_next;
    logic [31:0]      pkts_reg, pkts_next;
    logic [31:0]      bytes_reg, bytes_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;

    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] frames;
    logic [CNT_W:0]   chunk_bytes;
    logic             nz;
    logic             close;

    // Take a word when the output register is free or being drained
    assign pop       = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        count       = words_reg + CNT_W'(1);
        chunk_bytes = {count, 1'b0};
        frames      = cfg.stereo_mode ? (count >> 1) : count;
        nz          = chunk_nz_reg || item.nonzero;
        close       = item.end_of_call || (count >= CNT_W'(CHUNK_WORDS));

        words_next      = words_reg;
        chunk_nz_next   = chunk_nz_reg;
        was_silent_next = was_silent_reg;
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        pkts_next       = pkts_reg;
        bytes_next      = bytes_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (pop) begin
            out_data_next                   = '0;
            out_data_next.pcm_word          = item.pcm_word;
            out_data_next.word_index        = words_reg[8:0];
            if (close) begin
                // Close the chunk: advance timestamp, commit or drop
                out_data_next.chunk_end     = 1'b1;
                out_data_next.rtp_timestamp = ts_reg;
                out_data_next.payload_bytes = chunk_bytes[9:0];
                ts_next                     = ts_reg + 32'(frames);
                if (nz) begin
                    out_data_next.send_packet       = 1'b1;
                    out_data_next.header_first_word = RTP_VERSION_BITS
                        | (32'(was_silent_reg) << 23)
                        | (32'(cfg.payload_type) << 16)
                        | 32'(seq_reg);
                    out_data_next.header_source     = cfg.source_id;
                    was_silent_next = 1'b0;
                    seq_next        = seq_reg + 16'd1;
                    pkts_next       = pkts_reg + 32'd1;
                    bytes_next      = bytes_reg + 32'(chunk_bytes);
                end else begin
                    was_silent_next = 1'b1;
                end
                words_next    = '0;
                chunk_nz_next = 1'b0;
            end else begin
                words_next    = count;
                chunk_nz_next = nz;
            end
            out_data_next.packets_sent = pkts_next;
            out_data_next.bytes_sent   = bytes_next;
            out_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg      <= '0;
            chunk_nz_reg   <= 1'b0;
            was_silent_reg <= 1'b0;
            seq_reg        <= '0;
            ts_reg         <= '0;
            pkts_reg       <= '0;
            bytes_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            words_reg      <= words_next;
            chunk_nz_reg   <= chunk_nz_next;
            was_silent_reg <= was_silent_next;
            seq_reg        <= seq_next;
            ts_reg         <= ts_next;
            pkts_reg       <= pkts_next;
            bytes_reg      <= bytes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ verif/tb_pcm_rtp_packetizer_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pcm_rtp_packetizer_unit: drives Q2.22 samples with random
// gaps and output stalls, predicts every PCM word and chunk decision, checks each result.
// Depends on pcmrtp_pkg and the RTL of pcm_rtp_packetizer_unit.
module tb_pcm_rtp_packetizer_unit;
    import pcmrtp_pkg::*;

    localparam int SCALE_ONE   = 4194304;   // +1.0 in Q2.22
    localparam int PCM_MAX     = 32767;
    localparam int PCM_MIN     = -32768;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_SLACK = 4;
    localparam int END_SLACK   = 20;
    localparam int HOLD_CYCLES = 200;
    localparam int PRINT_CAP   = 50;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;     // [23:0] sample
    logic                 s_tlast   = 1'b0;   // end_of_call
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // see field map in check block below
    logic                 m_tlast;            // chunk_end
    logic                 m_tuser;            // send_packet
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    pcm_rtp_packetizer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Packetizer shadow state and configuration
    int          pred_words      = 0;
    logic        pred_nonzero    = 1'b0;
    logic        pred_was_silent = 1'b0;
    logic [15:0] pred_seq        = '0;
    logic [31:0] pred_ts         = '0;
    logic [31:0] pred_pkts       = '0;
    logic [31:0] pred_bytes      = '0;
    logic        cfg_stereo      = 1'b0;
    logic [6:0]  cfg_pt          = '0;
    logic [31:0] cfg_ssrc        = '0;

    result_t pending_words[$];

    int tx_max_gap    = 13;
    int rx_max_stall  = 13;
    int rx_hold_cycles = 0;

    int mismatches      = 0;
    int results_checked = 0;
    int samples_sent    = 0;
    int silent_chunks   = 0;
    int full_chunks     = 0;
    int input_stalls    = 0;
    int long_holds      = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Scale, clip and packetize one sample; advance the shadow state
    function automatic result_t packetize_sample(logic signed [23:0] smp, logic eoc);
        result_t r;
        int      s;
        longint  prod;
        int      count;
        int      frames;
        logic    marker;
        r = '0;
        s = int'(smp);
        if (s >= SCALE_ONE) begin
            r.pcm_word = 16'(PCM_MAX);
        end else if (s <= -SCALE_ONE) begin
            r.pcm_word = 16'(PCM_MIN);
        end else begin
            prod = longint'(PCM_MAX) * longint'(s);
            if (prod < 0) r.pcm_word = 16'(-((-prod) >>> 22));
            else          r.pcm_word = 16'(prod >>> 22);
        end
        r.word_index = 9'(pred_words);
        count = pred_words + 1;
        if (r.pcm_word != 0) pred_nonzero = 1'b1;
        if (eoc || count >= int'(CHUNK_WORDS)) begin
            // close the chunk: timestamp moves by frames, silent chunks are dropped
            if (count >= int'(CHUNK_WORDS)) full_chunks++;
            frames = cfg_stereo ? count / 2 : count;
            r.chunk_end     = 1'b1;
            r.rtp_timestamp = pred_ts;
            r.payload_bytes = 10'(count * 2);
            pred_ts += 32'(frames);
            if (pred_nonzero) begin
                marker = pred_was_silent;
                pred_was_silent     = 1'b0;
                r.send_packet       = 1'b1;
                r.header_first_word = RTP_VERSION_BITS | {8'h00, marker, cfg_pt, pred_seq};
                r.header_source     = cfg_ssrc;
                pred_seq   += 16'd1;
                pred_pkts  += 32'd1;
                pred_bytes += 32'(count * 2);
            end else begin
                pred_was_silent = 1'b1;
                silent_chunks++;
            end
            pred_words   = 0;
            pred_nonzero = 1'b0;
        end else begin
            pred_words = count;
        end
        r.packets_sent = pred_pkts;
        r.bytes_sent   = pred_bytes;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch in %s at result %0d: got %h, want %h",
                     $time, field, results_checked, got, want);
    endtask

    // Offer one sample after a random gap; predict it once accepted
    task automatic send_sample(input logic signed [23:0] smp, input logic eoc);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eoc;
        do @(posedge aclk); while (!s_tready);
        pending_words.push_back(packetize_sample(smp, eoc));
        samples_sent++;
    endtask

    // Drop the request line and hold until every expected word has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STEREO_MODE:  cfg_stereo = data[0];
            REG_PAYLOAD_TYPE: cfg_pt     = data[6:0];
            REG_SOURCE_ID:    cfg_ssrc   = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic stereo, input logic [6:0] pt,
                                input logic [31:0] ssrc);
        wait_drained();
        write_reg(REG_STEREO_MODE, {31'd0, stereo});
        write_reg(REG_PAYLOAD_TYPE, {25'd0, pt});
        write_reg(REG_SOURCE_ID, ssrc);
    endtask

    function automatic logic signed [23:0] gen_sample(input logic silent);
        int v;
        if (silent) begin
            // anything within +-128 LSB truncates to a zero word
            v = int'($urandom_range(0, 256)) - 128;
        end else begin
            case ($urandom_range(0, 5))
                3:       v = SCALE_ONE + int'($urandom_range(0, 8)) - 4;
                4:       v = -SCALE_ONE + int'($urandom_range(0, 8)) - 4;
                5:       v = int'($urandom_range(0, 2047)) - 1024;
                default: v = int'($urandom);
            endcase
        end
        return v[23:0];
    endfunction

    task automatic send_chunk(input int len, input logic silent, input logic close_eoc);
        for (int i = 0; i < len; i++)
            send_sample(gen_sample(silent), close_eoc && (i == len - 1));
    endtask

    // Clip limits, truncation toward zero, first packet without marker
    task automatic test_scaling_extremes();
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h40_0000, 1'b0);
        send_sample(24'h3F_FFFF, 1'b0);
        send_sample(24'h00_0001, 1'b0);
        send_sample(24'h00_0080, 1'b0);
        send_sample(24'h00_0081, 1'b0);
        send_sample(24'hFF_FFFF, 1'b0);
        send_sample(24'hC0_0001, 1'b0);
        send_sample(24'hC0_0000, 1'b0);
        send_sample(24'hBF_FFFF, 1'b0);
        send_sample(24'h80_0000, 1'b1);
    endtask

    // Silent chunk dropped, marker on the next packet only, single-word chunk
    task automatic test_silence_marker();
        send_sample(24'h00_0000, 1'b0);
        send_sample(24'h00_0080, 1'b0);
        send_sample(24'hFF_FF80, 1'b1);
        send_sample(24'h00_03E8, 1'b0);
        send_sample(24'hFF_EC78, 1'b1);
        send_sample(24'h20_0000, 1'b1);
    endtask

    // Stereo with odd word counts: frames round down, one-word chunks add none
    task automatic test_stereo_odd();
        write_config(1'b1, 7'h7F, 32'hFFFF_FFFF);
        send_sample(24'h12_3456, 1'b0);
        send_sample(24'hED_CBA9, 1'b0);
        send_sample(24'h00_0000, 1'b1);
        send_sample(24'h00_0000, 1'b1);
        send_sample(24'h7F_FFFF, 1'b1);
    endtask

    // Random chunks over several register settings and idling profiles
    task automatic test_random_traffic();
        int   start;
        int   len;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_config(1'b0, 7'h00, 32'h0000_0000);
                1: write_config(1'b1, 7'h7F, 32'hFFFF_FFFF);
                default: write_config(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                                      $urandom);
            endcase
            case (phase)
                0: begin tx_max_gap = 0;  rx_max_stall = 0;  end
                1: begin tx_max_gap = 13; rx_max_stall = 13; end
                2: begin tx_max_gap = 13; rx_max_stall = 0;  end
                default: begin tx_max_gap = 0; rx_max_stall = 13; end
            endcase
            // one chunk that fills to the size limit, sometimes also ending the call, silent in one phase
            if (phase == 1 || phase == 2)
                send_chunk(int'(CHUNK_WORDS) - pred_words, phase == 2,
                           1'($urandom_range(0, 1)));
            start = samples_sent;
            while (samples_sent - start < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(1, 24);
                send_chunk(len, $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0);
                if ($urandom_range(0, 15) == 0) wait_drained();
            end
        end
    endtask

    // Long output hold fills the block; then pause the sender until drained, then send with short gaps and stalls
    task automatic test_backpressure();
        wait_drained();
        tx_max_gap     = 0;
        rx_max_stall   = 0;
        rx_hold_cycles = HOLD_CYCLES;
        send_chunk(60, 1'b0, 1'b1);
        wait_drained();
        tx_max_gap   = 5;
        rx_max_stall = 5;
        send_chunk(30, 1'b0, 1'b1);
    endtask

    // Output ready: random stall per word, plus a long hold on request
    initial begin : result_sink
        int stall;
        int hold;
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                long_holds++;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) input_stalls++;
    end

    // Compare each accepted word with the oldest prediction
    // m_tdata: [15:0] pcm_word, [24:16] word_index, [56:25] header_first_word,
    // [88:57] rtp_timestamp, [120:89] header_source, [130:121] payload_bytes,
    // [162:131] packets_sent, [194:163] bytes_sent, [199:195] zero
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata[15:0] !== want.pcm_word)
                    report_mismatch("pcm_word", {16'd0, m_tdata[15:0]},
                                    {16'd0, want.pcm_word});
                if (m_tdata[24:16] !== want.word_index)
                    report_mismatch("word_index", {23'd0, m_tdata[24:16]},
                                    {23'd0, want.word_index});
                if (m_tlast !== want.chunk_end)
                    report_mismatch("chunk_end", {31'd0, m_tlast}, {31'd0, want.chunk_end});
                if (m_tuser !== want.send_packet)
                    report_mismatch("send_packet", {31'd0, m_tuser},
                                    {31'd0, want.send_packet});
                if (m_tdata[56:25] !== want.header_first_word)
                    report_mismatch("header_first_word", m_tdata[56:25],
                                    want.header_first_word);
                if (m_tdata[88:57] !== want.rtp_timestamp)
                    report_mismatch("rtp_timestamp", m_tdata[88:57], want.rtp_timestamp);
                if (m_tdata[120:89] !== want.header_source)
                    report_mismatch("header_source", m_tdata[120:89], want.header_source);
                if (m_tdata[130:121] !== want.payload_bytes)
                    report_mismatch("payload_bytes", {22'd0, m_tdata[130:121]},
                                    {22'd0, want.payload_bytes});
                if (m_tdata[162:131] !== want.packets_sent)
                    report_mismatch("packets_sent", m_tdata[162:131], want.packets_sent);
                if (m_tdata[194:163] !== want.bytes_sent)
                    report_mismatch("bytes_sent", m_tdata[194:163], want.bytes_sent);
                if (m_tdata[199:195] !== 5'd0)
                    report_mismatch("tdata padding", {27'd0, m_tdata[199:195]}, 32'd0);
            end
            results_checked++;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_scaling_extremes();
        test_silence_marker();
        test_stereo_odd();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (END_SLACK) @(posedge aclk);
        $display("covered %0d samples, %0d words checked, %0d packets, %0d silent drops",
                 samples_sent, results_checked, pred_pkts, silent_chunks);
        $display("size-closed chunks %0d, long output holds %0d, input stall cycles %0d",
                 full_chunks, long_holds, input_stalls);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("tb_pcm_rtp_packetizer_unit: clean");
        end else begin
            $display("tb_pcm_rtp_packetizer_unit: errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("tb_pcm_rtp_packetizer_unit: errors");
        $finish;
    end

endmodule

@@ pcm_rtp_packetizer_unit.f @@
rtl/pcmrtp_pkg.sv
rtl/pcmrtp_front.sv
rtl/pcmrtp_queue.sv
rtl/pcmrtp_back.sv
rtl/pcm_rtp_packetizer_unit.sv
verif/tb_pcm_rtp_packetizer_unit.sv
